@@ rtl/http_response_header_parser_defines.svh @@
// Assertion macros shared by the header parser RTL.
`ifndef HTTP_RESPONSE_HEADER_PARSER_DEFINES_SVH
`define HTTP_RESPONSE_HEADER_PARSER_DEFINES_SVH

// Same-cycle implication, checked on every rising clk edge outside reset.
`define HRHP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clk edge outside reset.
`define HRHP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/hrhp_pkg.sv @@
// Types, constants and lookup functions of the HTTP response header parser.
`timescale 1ns / 1ps
`default_nettype none

package hrhp_pkg;

    // Offset limit: bytes at or beyond this offset are an error
    localparam int MAX_HEADER_BYTES = 65536;
    localparam int OFFSET_LIMIT     = (MAX_HEADER_BYTES < 65536) ? MAX_HEADER_BYTES : 65536;
    localparam int POS_W            = $clog2(OFFSET_LIMIT + 1);

    localparam int STATUS_W          = 10;
    localparam int STATUS_PREFIX_LEN = 12;
    localparam int VERSION_DIGIT_POS = 7;
    localparam int FIRST_CODE_POS    = 9;
    localparam int KIND_COUNT        = 6;
    localparam int NAME_MAX          = 17;
    localparam int NAME_IDX_W        = $clog2(NAME_MAX);

    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
    localparam logic [7:0] CASE_BIT   = 8'h20;

    typedef enum logic [1:0] {
        PH_STATUS,
        PH_HEADERS,
        PH_DONE,
        PH_ERROR
    } phase_t;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_LINE  = 2'd1,
        EV_DONE  = 2'd2,
        EV_ERROR = 2'd3
    } event_t;

    typedef enum logic [2:0] {
        KIND_OTHER     = 3'd0,
        KIND_ENCODING  = 3'd1,
        KIND_LANGUAGE  = 3'd2,
        KIND_LENGTH    = 3'd3,
        KIND_TYPE      = 3'd4,
        KIND_LOCATION  = 3'd5,
        KIND_TRANSFER  = 3'd6
    } kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]          event_res;
        logic [STATUS_W-1:0] status_code;
        logic [2:0]          header_kind;
        logic [15:0]         name_offset;
        logic [15:0]         name_length;
        logic [15:0]         value_offset;
        logic [15:0]         value_length;
    } out_item_t;

    // Expected byte of the fixed "HTTP/1.x " prefix
    function automatic logic [7:0] prefix_char(input logic [3:0] i);
        logic [7:0] c;
        unique case (i)
            4'd0:    c = "H";
            4'd1:    c = "T";
            4'd2:    c = "T";
            4'd3:    c = "P";
            4'd4:    c = "/";
            4'd5:    c = "1";
            4'd6:    c = ".";
            4'd8:    c = " ";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Length of known header name k (k = kind - 1)
    function automatic logic [NAME_IDX_W-1:0] kind_len(input logic [2:0] k);
        logic [NAME_IDX_W-1:0] n;
        unique case (k)
            3'd0:    n = NAME_IDX_W'(16);
            3'd1:    n = NAME_IDX_W'(16);
            3'd2:    n = NAME_IDX_W'(14);
            3'd3:    n = NAME_IDX_W'(12);
            3'd4:    n = NAME_IDX_W'(8);
            3'd5:    n = NAME_IDX_W'(17);
            default: n = '0;
        endcase
        return n;
    endfunction

    // Lower-case byte i of known header name k; names are left aligned
    function automatic logic [7:0] kind_char(input logic [2:0] k,
                                             input logic [NAME_IDX_W-1:0] i);
        logic [8*NAME_MAX-1:0] s;
        logic [7:0]            c;
        unique case (k)
            3'd0:    s = {"content-encoding", 8'h00};
            3'd1:    s = {"content-language", 8'h00};
            3'd2:    s = {"content-length", 24'h0};
            3'd3:    s = {"content-type", 40'h0};
            3'd4:    s = {"location", 72'h0};
            3'd5:    s = "transfer-encoding";
            default: s = '0;
        endcase
        if (int'(i) < NAME_MAX)
        begin
            c = s[8*(NAME_MAX - 1 - int'(i)) +: 8];
        end
        else
        begin
            c = 8'h00;
        end
        return c;
    endfunction

    // ASCII lower-case fold
    function automatic logic [7:0] to_lower(input logic [7:0] b);
        return (b >= CHAR_UP_A && b <= CHAR_UP_Z) ? (b | CASE_BIT) : b;
    endfunction

endpackage

`default_nettype wire

@@ rtl/hrhp_core.sv @@
// Parser state registers and the per-byte next-state and result logic.
`timescale 1ns / 1ps
`default_nettype none

module hrhp_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step_en,
    input  wire hrhp_pkg::in_item_t  item,
    output hrhp_pkg::out_item_t      result
);

    localparam int PW = hrhp_pkg::POS_W;

    hrhp_pkg::phase_t phase_reg, phase_next;
    logic [PW-1:0]    pos_reg, pos_next;
    logic [hrhp_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [PW-1:0]    line_start_reg, line_start_next;
    logic             colon_seen_reg, colon_seen_next;
    logic [PW-1:0]    colon_off_reg, colon_off_next;
    logic [PW-1:0]    value_start_reg, value_start_next;
    logic             skip_ws_reg, skip_ws_next;
    logic             cr_pend_reg, cr_pend_next;
    logic [hrhp_pkg::KIND_COUNT-1:0] flags_reg, flags_next;

    // Current view of the state: a first byte restarts everything
    hrhp_pkg::phase_t cur_phase;
    logic [PW-1:0]    cur_pos;
    logic [hrhp_pkg::STATUS_W-1:0] cur_status;
    logic [PW-1:0]    cur_line_start;
    logic             cur_colon_seen;
    logic [PW-1:0]    cur_colon_off;
    logic [PW-1:0]    cur_value_start;
    logic             cur_skip_ws;
    logic             cur_cr_pend;
    logic [hrhp_pkg::KIND_COUNT-1:0] cur_flags;

    always_comb
    begin
        if (item.first_byte)
        begin
            cur_phase       = hrhp_pkg::PH_STATUS;
            cur_pos         = '0;
            cur_status      = '0;
            cur_line_start  = '0;
            cur_colon_seen  = 1'b0;
            cur_colon_off   = '0;
            cur_value_start = '0;
            cur_skip_ws     = 1'b0;
            cur_cr_pend     = 1'b0;
            cur_flags       = '1;
        end
        else
        begin
            cur_phase       = phase_reg;
            cur_pos         = pos_reg;
            cur_status      = status_reg;
            cur_line_start  = line_start_reg;
            cur_colon_seen  = colon_seen_reg;
            cur_colon_off   = colon_off_reg;
            cur_value_start = value_start_reg;
            cur_skip_ws     = skip_ws_reg;
            cur_cr_pend     = cr_pend_reg;
            cur_flags       = flags_reg;
        end
    end

    // Per-byte step
    logic [7:0]       b;
    logic [7:0]       b_low;
    logic [PW-1:0]    pos_inc;
    logic [PW-1:0]    cr_pos;
    logic [PW-1:0]    name_idx;
    logic [PW-1:0]    name_len;
    hrhp_pkg::event_t ev;
    logic [2:0]       kind;
    logic [PW-1:0]    r_no, r_nl, r_vo, r_vl;

    always_comb
    begin
        b        = item.data_byte;
        b_low    = hrhp_pkg::to_lower(b);
        pos_inc  = cur_pos + PW'(1);
        cr_pos   = cur_pos - PW'(1);
        name_idx = cur_pos - cur_line_start;
        name_len = cur_colon_off - cur_line_start;

        phase_next       = cur_phase;
        pos_next         = cur_pos;
        status_next      = cur_status;
        line_start_next  = cur_line_start;
        colon_seen_next  = cur_colon_seen;
        colon_off_next   = cur_colon_off;
        value_start_next = cur_value_start;
        skip_ws_next     = cur_skip_ws;
        cr_pend_next     = cur_cr_pend;
        flags_next       = cur_flags;

        ev   = hrhp_pkg::EV_NONE;
        kind = hrhp_pkg::KIND_OTHER;
        r_no = '0;
        r_nl = '0;
        r_vo = '0;
        r_vl = '0;

        if (cur_phase == hrhp_pkg::PH_STATUS || cur_phase == hrhp_pkg::PH_HEADERS)
        begin
            if (int'(cur_pos) >= hrhp_pkg::OFFSET_LIMIT)
            begin
                ev = hrhp_pkg::EV_ERROR;
            end
            else
            begin
                pos_next = pos_inc;
                if (cur_phase == hrhp_pkg::PH_STATUS)
                begin
                    // Status line: fixed prefix, version digit, three code digits, CRLF
                    if (int'(cur_pos) < hrhp_pkg::VERSION_DIGIT_POS ||
                        int'(cur_pos) == hrhp_pkg::VERSION_DIGIT_POS + 1)
                    begin
                        if (b != hrhp_pkg::prefix_char(cur_pos[3:0]))
                        begin
                            ev = hrhp_pkg::EV_ERROR;
                        end
                    end
                    else if (int'(cur_pos) < hrhp_pkg::STATUS_PREFIX_LEN)
                    begin
                        if (b < hrhp_pkg::CHAR_ZERO || b > hrhp_pkg::CHAR_NINE)
                        begin
                            ev = hrhp_pkg::EV_ERROR;
                        end
                        else if (int'(cur_pos) >= hrhp_pkg::FIRST_CODE_POS)
                        begin
                            status_next = hrhp_pkg::STATUS_W'(cur_status * 10'd10)
                                        + hrhp_pkg::STATUS_W'(b - hrhp_pkg::CHAR_ZERO);
                        end
                    end
                    else if (b == hrhp_pkg::CHAR_LF && cur_cr_pend)
                    begin
                        phase_next       = hrhp_pkg::PH_HEADERS;
                        line_start_next  = pos_inc;
                        colon_seen_next  = 1'b0;
                        colon_off_next   = pos_inc;
                        value_start_next = pos_inc;
                        skip_ws_next     = 1'b0;
                        cr_pend_next     = 1'b0;
                        flags_next       = '1;
                    end
                    else
                    begin
                        cr_pend_next = (b == hrhp_pkg::CHAR_CR);
                    end
                    if (ev == hrhp_pkg::EV_NONE && item.last_byte)
                    begin
                        ev = (phase_next == hrhp_pkg::PH_HEADERS) ? hrhp_pkg::EV_DONE
                                                                  : hrhp_pkg::EV_ERROR;
                    end
                end
                else if (b == hrhp_pkg::CHAR_LF && cur_cr_pend)
                begin
                    // End of a header line
                    if (cr_pos == cur_line_start)
                    begin
                        ev = hrhp_pkg::EV_DONE;
                    end
                    else if (!cur_colon_seen)
                    begin
                        ev = hrhp_pkg::EV_ERROR;
                    end
                    else
                    begin
                        // lowest matching kind wins
                        for (int k = hrhp_pkg::KIND_COUNT - 1; k >= 0; k--)
                        begin
                            if (cur_flags[k] &&
                                name_len == PW'(hrhp_pkg::kind_len(3'(k))))
                            begin
                                kind = 3'(k + 1);
                            end
                        end
                        ev               = hrhp_pkg::EV_LINE;
                        r_no             = cur_line_start;
                        r_nl             = name_len;
                        r_vo             = cur_value_start;
                        r_vl             = cr_pos - cur_value_start;
                        line_start_next  = pos_inc;
                        colon_seen_next  = 1'b0;
                        colon_off_next   = pos_inc;
                        value_start_next = pos_inc;
                        skip_ws_next     = 1'b0;
                        cr_pend_next     = 1'b0;
                        flags_next       = '1;
                        if (item.last_byte)
                        begin
                            phase_next = hrhp_pkg::PH_DONE;
                        end
                    end
                end
                else
                begin
                    // Ordinary line byte: name match, colon, value whitespace
                    if (!cur_colon_seen)
                    begin
                        if (b == hrhp_pkg::CHAR_COLON)
                        begin
                            colon_seen_next  = 1'b1;
                            colon_off_next   = cur_pos;
                            value_start_next = pos_inc;
                            skip_ws_next     = 1'b1;
                        end
                        else
                        begin
                            for (int k = 0; k < hrhp_pkg::KIND_COUNT; k++)
                            begin
                                if (name_idx >= PW'(hrhp_pkg::kind_len(3'(k))) ||
                                    b_low != hrhp_pkg::kind_char(3'(k),
                                        name_idx[hrhp_pkg::NAME_IDX_W-1:0]))
                                begin
                                    flags_next[k] = 1'b0;
                                end
                            end
                        end
                    end
                    else if (cur_skip_ws)
                    begin
                        if (b == hrhp_pkg::CHAR_SPACE || b == hrhp_pkg::CHAR_TAB)
                        begin
                            value_start_next = pos_inc;
                        end
                        else
                        begin
                            skip_ws_next = 1'b0;
                        end
                    end
                    cr_pend_next = (b == hrhp_pkg::CHAR_CR);
                    if (item.last_byte)
                    begin
                        ev = hrhp_pkg::EV_ERROR;
                    end
                end
            end

            if (ev == hrhp_pkg::EV_DONE)
            begin
                phase_next = hrhp_pkg::PH_DONE;
            end
            else if (ev == hrhp_pkg::EV_ERROR)
            begin
                phase_next = hrhp_pkg::PH_ERROR;
            end
        end

        // Result transaction
        result.event_res    = ev;
        result.status_code  = (ev == hrhp_pkg::EV_LINE || ev == hrhp_pkg::EV_DONE)
                              ? status_next : '0;
        result.header_kind  = kind;
        result.name_offset  = 16'(r_no);
        result.name_length  = 16'(r_nl);
        result.value_offset = 16'(r_vo);
        result.value_length = 16'(r_vl);
    end

    // State registers, updated once per processed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= hrhp_pkg::PH_STATUS;
            pos_reg         <= '0;
            status_reg      <= '0;
            line_start_reg  <= '0;
            colon_seen_reg  <= 1'b0;
            colon_off_reg   <= '0;
            value_start_reg <= '0;
            skip_ws_reg     <= 1'b0;
            cr_pend_reg     <= 1'b0;
            flags_reg       <= '1;
        end
        else if (step_en)
        begin
            phase_reg       <= phase_next;
            pos_reg         <= pos_next;
            status_reg      <= status_next;
            line_start_reg  <= line_start_next;
            colon_seen_reg  <= colon_seen_next;
            colon_off_reg   <= colon_off_next;
            value_start_reg <= value_start_next;
            skip_ws_reg     <= skip_ws_next;
            cr_pend_reg     <= cr_pend_next;
            flags_reg       <= flags_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/http_response_header_parser.sv @@
// Top level of the HTTP/1.x response header parser: handshakes and pipeline registers.
//
// Input channel byte_valid / byte_stall / byte_data carries one header byte per
// transaction, with first_byte (restart) and last_byte (end of text) marks.
// Output channel hdr_valid / hdr_stall / hdr_data carries exactly one result per
// input byte: event code, status code, header kind, and name/value offsets and
// lengths. A transaction completes on a clock edge with valid high and stall low.
// A byte accepted into the input register gives its result in the result register
// behind the parse logic.
// Throughput: one byte per cycle while the result side does not stall; the parse
// state advances once per byte, so consecutive bytes flow back to back.
// When hdr_stall holds a result, the input register still takes one more byte;
// byte_stall rises only while both the input and result registers are full.
// Reset (rst_n low) empties both registers and returns the parser to the start
// of a status line with all offsets at zero.
`timescale 1ns / 1ps
`default_nettype none
`include "http_response_header_parser_defines.svh"

module http_response_header_parser (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               byte_valid,
    output logic                    byte_stall,
    input  wire hrhp_pkg::in_item_t byte_data,
    output logic                    hdr_valid,
    input  wire logic               hdr_stall,
    output hrhp_pkg::out_item_t     hdr_data
);

    logic                in_valid_reg, in_valid_next;
    hrhp_pkg::in_item_t  in_data_reg;
    logic                out_valid_reg, out_valid_next;
    hrhp_pkg::out_item_t out_data_reg;
    hrhp_pkg::out_item_t step_result;
    logic                advance;
    logic                fire;
    logic                in_take;

    // Pipeline control
    always_comb
    begin
        advance        = !out_valid_reg || !hdr_stall;
        fire           = in_valid_reg && advance;
        byte_stall     = in_valid_reg && !advance;
        in_take        = byte_valid && !byte_stall;
        in_valid_next  = in_take ? 1'b1 : (fire ? 1'b0 : in_valid_reg);
        out_valid_next = fire ? 1'b1 : (hdr_stall ? out_valid_reg : 1'b0);
    end

    hrhp_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (fire),
        .item    (in_data_reg),
        .result  (step_result)
    );

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_data_reg <= byte_data;
        end
        if (fire)
        begin
            out_data_reg <= step_result;
        end
    end

    assign hdr_valid = out_valid_reg;
    assign hdr_data  = out_data_reg;

    // Checks
    `HRHP_ASSERT_SAME(a_stall_only_when_full, byte_stall, in_valid_reg && out_valid_reg && hdr_stall, "input stalled while a register is free")
    `HRHP_ASSERT_NEXT(a_fire_gives_result, fire, hdr_valid, "processed byte produced no result")
    `HRHP_ASSERT_SAME(a_fields_zero_off_line, hdr_valid && hdr_data.event_res != hrhp_pkg::EV_LINE, hdr_data.header_kind == 3'd0 && hdr_data.name_length == 16'd0 && hdr_data.value_length == 16'd0, "line fields set without a header line event")
    `HRHP_ASSERT_SAME(a_status_zero_off_event, hdr_valid && (hdr_data.event_res == hrhp_pkg::EV_NONE || hdr_data.event_res == hrhp_pkg::EV_ERROR), hdr_data.status_code == 10'd0, "status code set on a none or error event")

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// Self-checking testbench for the HTTP/1.x response header parser.
`timescale 1ns / 1ps

module tb_top;
    import hrhp_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int REPORT_CAP  = 40;
    localparam int PHASE_ITEMS = 230;
    localparam int SEND_IDLE[4]  = '{0, 57, 0, 29};
    localparam int RECV_STALL[4] = '{0, 0, 57, 29};

    typedef struct {
        in_item_t  item;
        bit        pinned;
        out_item_t want;
    } feed_t;

    typedef struct {
        string     text;
        bit        first;
        bit        last;
        bit        pinned;
        out_item_t want;
    } dir_row_t;

    logic      clk;
    logic      rst_n = 1'b0;
    logic      byte_valid = 1'b0;
    logic      byte_stall;
    in_item_t  byte_data = '0;
    logic      hdr_valid;
    logic      hdr_stall = 1'b0;
    out_item_t hdr_data;

    feed_t      byte_feed[$];
    out_item_t  parsed_q[$];
    dir_row_t   dir_rows[$];
    logic [7:0] draft[$];

    int        cycle_count = 0;
    int        mismatches = 0;
    int        live_count = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    bit        cur_pinned = 1'b0;
    out_item_t cur_want = '0;

    // Known header names, index k gives kind k + 1
    string known_names[6] = '{"content-encoding", "content-language", "content-length",
                              "content-type", "location", "transfer-encoding"};
    string status_lead = "HTTP/1.0 ";

    // Parser state mirror
    phase_t     pr_phase;
    int         pr_pos;
    int         pr_status;
    int         pr_line_start;
    int         pr_colon_at;
    int         pr_value_start;
    bit         pr_colon_seen;
    bit         pr_skip_ws;
    bit         pr_cr;
    bit         pr_live;
    logic [5:0] pr_match;

    http_response_header_parser dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .hdr_valid  (hdr_valid),
        .hdr_stall  (hdr_stall),
        .hdr_data   (hdr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Fresh header line starting at offset at
    function automatic void open_line(int at);
        pr_line_start  = at;
        pr_colon_seen  = 1'b0;
        pr_colon_at    = at;
        pr_value_start = at;
        pr_skip_ws     = 1'b0;
        pr_cr          = 1'b0;
        pr_match       = '1;
    endfunction

    function automatic void restart_parse();
        pr_phase  = PH_STATUS;
        pr_pos    = 0;
        pr_status = 0;
        open_line(0);
    endfunction

    // Advance the mirror by one byte and return the result it produces
    function automatic out_item_t parse_byte(in_item_t it);
        out_item_t  r;
        event_t     ev;
        kind_t      kind;
        logic [7:0] b;
        logic [7:0] low;
        int         p;
        int         cr;
        int         nlen;
        int         idx;
        r = '0;
        ev = EV_NONE;
        kind = KIND_OTHER;
        b = it.data_byte;
        pr_live = 1'b0;
        if (it.first_byte)
            restart_parse();
        if (pr_phase != PH_STATUS && pr_phase != PH_HEADERS)
            return r;
        pr_live = 1'b1;
        p = pr_pos;
        if (p >= OFFSET_LIMIT)
        begin
            pr_phase = PH_ERROR;
            r.event_res = EV_ERROR;
            return r;
        end
        pr_pos = p + 1;

        if (pr_phase == PH_STATUS)
        begin
            // fixed prefix, version digit, three code digits, then reason to CRLF
            if (p < VERSION_DIGIT_POS || p == VERSION_DIGIT_POS + 1)
            begin
                if (b != 8'(status_lead[p]))
                    ev = EV_ERROR;
            end
            else if (p < STATUS_PREFIX_LEN)
            begin
                if (b < CHAR_ZERO || b > CHAR_NINE)
                    ev = EV_ERROR;
                else if (p >= FIRST_CODE_POS)
                    pr_status = pr_status * 10 + int'(b - CHAR_ZERO);
            end
            else if (b == CHAR_LF && pr_cr)
            begin
                pr_phase = PH_HEADERS;
                open_line(p + 1);
            end
            else
                pr_cr = (b == CHAR_CR);
            if (ev == EV_NONE && it.last_byte)
                ev = (pr_phase == PH_HEADERS) ? EV_DONE : EV_ERROR;
        end
        else if (b == CHAR_LF && pr_cr)
        begin
            cr = p - 1;
            if (cr == pr_line_start)
                ev = EV_DONE;
            else if (!pr_colon_seen)
                ev = EV_ERROR;
            else
            begin
                nlen = pr_colon_at - pr_line_start;
                for (int k = 0; k < KIND_COUNT; k++)
                    if (kind == KIND_OTHER && pr_match[k] && known_names[k].len() == nlen)
                        kind = kind_t'(k + 1);
                ev = EV_LINE;
                r.header_kind  = kind;
                r.name_offset  = 16'(pr_line_start);
                r.name_length  = 16'(nlen);
                r.value_offset = 16'(pr_value_start);
                r.value_length = 16'(cr - pr_value_start);
                open_line(p + 1);
                if (it.last_byte)
                    pr_phase = PH_DONE;
            end
        end
        else
        begin
            idx = p - pr_line_start;
            if (!pr_colon_seen)
            begin
                if (b == CHAR_COLON)
                begin
                    pr_colon_seen  = 1'b1;
                    pr_colon_at    = p;
                    pr_value_start = p + 1;
                    pr_skip_ws     = 1'b1;
                end
                else
                begin
                    // case-folded name compare drops every known name that differs
                    low = (b >= CHAR_UP_A && b <= CHAR_UP_Z) ? b + 8'd32 : b;
                    for (int k = 0; k < KIND_COUNT; k++)
                    begin
                        if (idx >= known_names[k].len())
                            pr_match[k] = 1'b0;
                        else if (low != 8'(known_names[k][idx]))
                            pr_match[k] = 1'b0;
                    end
                end
            end
            else if (pr_skip_ws)
            begin
                if (b == CHAR_SPACE || b == CHAR_TAB)
                    pr_value_start = p + 1;
                else
                    pr_skip_ws = 1'b0;
            end
            pr_cr = (b == CHAR_CR);
            if (it.last_byte)
                ev = EV_ERROR;
        end

        if (ev == EV_DONE)
            pr_phase = PH_DONE;
        else if (ev == EV_ERROR)
            pr_phase = PH_ERROR;
        r.event_res = ev;
        if (ev == EV_LINE || ev == EV_DONE)
            r.status_code = 10'(pr_status);
        return r;
    endfunction

    function automatic out_item_t bare_result(event_t ev, int code);
        out_item_t r;
        r = '0;
        r.event_res = ev;
        r.status_code = 10'(code);
        return r;
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= REPORT_CAP)
                $error("%s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    function automatic void feed_one(logic [7:0] b, bit first, bit last, bit pinned,
                                     out_item_t want);
        feed_t f;
        f.item.data_byte  = b;
        f.item.first_byte = first;
        f.item.last_byte  = last;
        f.pinned = pinned;
        f.want   = want;
        byte_feed.insert(byte_feed.size(), f);
    endfunction

    // Marks go on the first and last byte; a pinned result belongs to the last byte
    function automatic void feed_text(string s, bit first, bit last, bit pinned,
                                      out_item_t want);
        for (int i = 0; i < s.len(); i++)
            feed_one(8'(s[i]), first && i == 0, last && i == s.len() - 1,
                     pinned && i == s.len() - 1, want);
    endfunction

    function automatic void add_byte(logic [7:0] b);
        draft.insert(draft.size(), b);
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(8'(s[i]));
    endfunction

    function automatic void add_row(string text, bit first, bit last, bit pinned,
                                    out_item_t want);
        dir_row_t row;
        row.text   = text;
        row.first  = first;
        row.last   = last;
        row.pinned = pinned;
        row.want   = want;
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    function automatic logic [7:0] printable();
        return 8'($urandom_range(32, 126));
    endfunction

    // Mostly well-formed responses with random content; some cut, corrupted or raw noise
    function automatic void queue_response();
        string      nm;
        logic [7:0] c;
        int         mode;
        int         cut;
        bit         lead;
        if ($urandom_range(99) < 6)
        begin
            repeat ($urandom_range(1, 8))
                feed_one(8'($urandom_range(255)), $urandom_range(7) == 0,
                         $urandom_range(7) == 0, 1'b0, '0);
            return;
        end
        draft = {};

        // status line with random version digit, code and reason
        add_text("HTTP/1.");
        add_byte(CHAR_ZERO + 8'($urandom_range(9)));
        add_byte(CHAR_SPACE);
        repeat (3)
            add_byte(CHAR_ZERO + 8'($urandom_range(9)));
        repeat ($urandom_range(0, 6))
            add_byte(printable());
        if ($urandom_range(9) == 0)
        begin
            add_byte(CHAR_CR);
            add_byte(printable());
        end
        add_text("\015\n");

        // header lines
        repeat ($urandom_range(0, 5))
        begin
            if ($urandom_range(99) < 60)
            begin
                nm = known_names[$urandom_range(KIND_COUNT - 1)];
                if ($urandom_range(9) == 0)
                    nm = nm.substr(0, nm.len() - 2);
                for (int i = 0; i < nm.len(); i++)
                begin
                    c = 8'(nm[i]);
                    if (c >= "a" && c <= "z" && $urandom_range(1))
                        c = c - 8'd32;
                    add_byte(c);
                end
            end
            else
            begin
                repeat ($urandom_range(1, 10))
                begin
                    c = 8'($urandom_range(33, 126));
                    add_byte(c == CHAR_COLON ? 8'h2D : c);
                end
            end
            add_byte(CHAR_COLON);
            repeat ($urandom_range(0, 3))
                add_byte($urandom_range(1) ? CHAR_SPACE : CHAR_TAB);
            repeat ($urandom_range(0, 12))
                add_byte(printable());
            if ($urandom_range(9) == 0)
            begin
                add_byte(CHAR_CR);
                add_byte(printable());
            end
            add_text("\015\n");
        end
        if ($urandom_range(99) < 85)
            add_text("\015\n");
        repeat ($urandom_range(0, 3))
            add_byte(8'($urandom_range(255)));

        // cut short, corrupt one byte, or leave the end unmarked
        mode = $urandom_range(99);
        if (mode < 12)
        begin
            cut = $urandom_range(1, draft.size());
            while (draft.size() > cut)
                void'(draft.pop_back());
        end
        else if (mode < 22)
            draft[$urandom_range(draft.size() - 1)] = 8'($urandom_range(255));
        lead = ($urandom_range(99) < 92);
        for (int i = 0; i < draft.size(); i++)
            feed_one(draft[i], lead && i == 0,
                     !(mode >= 22 && mode < 36) && i == draft.size() - 1, 1'b0, '0);
    endfunction

    task automatic wait_drained();
        while (byte_feed.size() != 0 || byte_valid || parsed_q.size() != 0)
            @(negedge clk);
    endtask

    // Byte side driver, result side stall and result checking
    always @(posedge clk)
    begin : channel_side
        feed_t     f;
        out_item_t got;
        if (rst_n)
        begin
            // transaction on the byte side: predict its result
            if (byte_valid && !byte_stall)
            begin
                got = parse_byte(byte_data);
                if (pr_live)
                    live_count++;
                parsed_q.insert(parsed_q.size(), cur_pinned ? cur_want : got);
            end
            if (!byte_valid || !byte_stall)
            begin
                if (byte_feed.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    f = byte_feed.pop_front();
                    byte_valid <= 1'b1;
                    byte_data  <= f.item;
                    cur_pinned = f.pinned;
                    cur_want   = f.want;
                end
                else
                    byte_valid <= 1'b0;
            end
            hdr_stall <= ($urandom_range(99) < recv_stall_pct);

            // transaction on the result side: compare with the oldest prediction
            if (hdr_valid && !hdr_stall)
            begin
                if (parsed_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_CAP)
                        $error("hdr_data: result with nothing outstanding");
                end
                else
                begin
                    got = parsed_q.pop_front();
                    check_field("event_res", got.event_res, hdr_data.event_res);
                    check_field("status_code", got.status_code, hdr_data.status_code);
                    check_field("header_kind", got.header_kind, hdr_data.header_kind);
                    check_field("name_offset", got.name_offset, hdr_data.name_offset);
                    check_field("name_length", got.name_length, hdr_data.name_length);
                    check_field("value_offset", got.value_offset, hdr_data.value_offset);
                    check_field("value_length", got.value_length, hdr_data.value_length);
                end
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("FAIL http_response_header_parser");
        $finish;
    end

    initial
    begin
        int target;
        restart_parse();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed part: text, first mark, last mark, pinned result of the last byte
        add_row("HTTP/1.1 200 OK\015\n", 1'b1, 1'b0, 1'b0, '0);
        add_row("Content-Length: 42\015\n", 1'b0, 1'b0, 1'b0, '0);
        add_row("content-TYPE:\t text/html\015\n", 1'b0, 1'b0, 1'b0, '0);
        add_row("Location:\015\n", 1'b0, 1'b0, 1'b0, '0);
        add_row("Transfer-Encoding: chunked\015\n", 1'b0, 1'b0, 1'b0, '0);
        add_row("CONTENT-ENCODING:gzip\015\n", 1'b0, 1'b0, 1'b0, '0);
        add_row("Content-Language: en\015\n", 1'b0, 1'b0, 1'b0, '0);
        add_row("X-A\015B: v\015\n", 1'b0, 1'b0, 1'b0, '0);
        add_row("Content-Lengthy: 1\015\n", 1'b0, 1'b0, 1'b0, '0);
        add_row("\015\n", 1'b0, 1'b0, 1'b1, bare_result(EV_DONE, 200));
        add_row("zz", 1'b0, 1'b1, 1'b1, bare_result(EV_NONE, 0));
        add_row("HTTP/1.0 999 \015\n", 1'b1, 1'b1, 1'b1, bare_result(EV_DONE, 999));
        add_row("HTTP/1.9 000 x\015\nA:b\015\n", 1'b1, 1'b1, 1'b0, '0);
        add_row("Q", 1'b0, 1'b0, 1'b1, bare_result(EV_NONE, 0));
        add_row("HTTP/2", 1'b1, 1'b0, 1'b1, bare_result(EV_ERROR, 0));
        add_row("HTTP/1.x", 1'b1, 1'b0, 1'b1, bare_result(EV_ERROR, 0));
        add_row("HTTP/1.1 20", 1'b1, 1'b1, 1'b1, bare_result(EV_ERROR, 0));
        add_row("HTTP/1.1 404 Not Found\015\n", 1'b1, 1'b0, 1'b0, '0);
        add_row("NoColonHere\015\n", 1'b0, 1'b0, 1'b1, bare_result(EV_ERROR, 0));
        add_row("HTTP/1.1 301\015\nLocation: /x", 1'b1, 1'b1, 1'b1,
                bare_result(EV_ERROR, 0));
        add_row("HTTP/1.1 204\015\n\015\nbody", 1'b1, 1'b0, 1'b1,
                bare_result(EV_NONE, 0));
        add_row("HTTP/1.1 200 a\015b\015\n:\015\n\015\n", 1'b1, 1'b0, 1'b1,
                bare_result(EV_DONE, 200));
        foreach (dir_rows[r])
            feed_text(dir_rows[r].text, dir_rows[r].first, dir_rows[r].last,
                      dir_rows[r].pinned, dir_rows[r].want);
        wait_drained();

        // random responses under each idling pattern
        for (int ph = 0; ph < 4; ph++)
        begin
            @(negedge clk);
            send_idle_pct  = SEND_IDLE[ph];
            recv_stall_pct = RECV_STALL[ph];
            target = live_count + PHASE_ITEMS;
            while (live_count < target)
            begin
                if (byte_feed.size() < 32)
                    queue_response();
                else
                    @(negedge clk);
            end
            wait_drained();
        end
        repeat (8) @(posedge clk);

        if (mismatches == 0 && parsed_q.size() == 0)
            $display("PASS http_response_header_parser");
        else
            $display("FAIL http_response_header_parser");
        $finish;
    end

endmodule
